### hdl/ssrb_pkg.sv
`default_nettype none

package ssrb_pkg;

   // field widths fixed by the stream and register formats
   localparam int DATA_W      = 8;
   localparam int FADDR_W     = 12;
   localparam int ACT_W       = 2;
   localparam int XPOS_W      = 9;
   localparam int YPOS_W      = 8;
   localparam int ROWS_W      = 9;
   localparam int COLS_W      = 7;
   localparam int ROP_W       = 2;
   localparam int STRIDE_W    = 7;
   localparam int ROWBASE_W   = 16;
   localparam int ORIGIN_W    = 16;
   localparam int PROD_W      = YPOS_W + STRIDE_W;
   localparam int SUM_W       = 18;
   localparam int REQ_TDATA_W = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 9;

   // result queue
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = 2;
   localparam int RSP_CNT_W   = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_POS         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_POS         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_ROW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RASTER_OP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE   = 3'd5;

   typedef enum logic [ACT_W-1:0] {
      ACT_SPRITE = 2'd0,
      ACT_READ   = 2'd1,
      ACT_WRITE  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [ROP_W-1:0] {
      ROP_OR   = 2'd0,
      ROP_AND  = 2'd1,
      ROP_XOR  = 2'd2,
      ROP_KEEP = 2'd3
   } rop_type;

   typedef enum logic [1:0] {
      UOP_COMBINE,
      UOP_STORE,
      UOP_LOAD,
      UOP_IDLE
   } uop_kind_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              blit_done;
      logic              out_of_range;
   } rsp_word_type;

endpackage

`default_nettype wire

### hdl/ssrb_rsp_fifo.sv
`default_nettype none

module ssrb_rsp_fifo
   import ssrb_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push_valid,
   input  wire rsp_word_type       push_word,
   input  wire                     pop_ready,
   output logic                    pop_valid,
   output rsp_word_type            pop_word,
   output logic [RSP_CNT_W-1:0]    level
);

   rsp_word_type         slot_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] level_ff, level_in;
   logic                 pop;

   assign pop_valid = (level_ff != '0);
   assign pop_word  = slot_ff[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_valid);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      level_in  = level_ff + RSP_CNT_W'(push_valid) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

### hdl/shifted_sprite_raster_blit_top.sv
`default_nettype none

// One-bit-per-pixel sprite blitter over an internal byte framebuffer of FRAME_BYTES bytes.
// Sprite bytes (action 0) are OR-, AND- or XOR-combined into the framebuffer (or leave it
// as it is under the keep operation) at the configured position, shifted by x_pos mod 8;
// host reads and writes (actions 1 and 2) reach the framebuffer directly. Every word in
// gives exactly one result word, which passes the issue stage, the memory stage and the
// result queue and waits there behind earlier results. An aligned sprite byte, a host
// read or a host write takes one memory operation; a sprite byte with x_pos mod 8 nonzero
// takes two, one read-modify-write for each destination byte, and a new word is taken as
// the held word issues its last operation, unless the result queue is full. After reset
// the framebuffer is cleared one byte a cycle, and no word is accepted until the clear is
// done; register writes are taken at all times but must only be issued while the block is
// idle. A write to one of the six registers restarts the blit at its first byte.
module shifted_sprite_raster_blit_top
   import ssrb_pkg::*;
#(
   parameter int FRAME_BYTES = 4096
)
(
   input  wire                     clock,
   input  wire                     reset,

   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  wire [REQ_TDATA_W-1:0]   req_tdata,   // data_byte [7:0], fb_address [19:8], zero [23:20]
   input  wire [ACT_W-1:0]         req_tuser,   // action [1:0]

   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [DATA_W-1:0]       rsp_tdata,   // read_data [7:0]
   output logic                    rsp_tlast,
   output logic [0:0]              rsp_tuser,   // out_of_range [0]

   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [CSR_IDX_W-1:0]     csr_index,
   input  wire [CSR_DATA_W-1:0]    csr_data
);

   localparam int AW = $clog2(FRAME_BYTES);
   localparam logic [SUM_W-1:0] FRAME_LIMIT = SUM_W'(FRAME_BYTES);
   localparam logic [AW-1:0]    CLEAR_LAST  = AW'(FRAME_BYTES - 1);

   // registers
   logic [XPOS_W-1:0]    x_pos_ff;
   logic [YPOS_W-1:0]    y_pos_ff;
   logic [ROWS_W-1:0]    row_count_ff;
   logic [COLS_W-1:0]    bytes_per_row_ff;
   rop_type              raster_op_ff;
   logic [STRIDE_W-1:0]  line_stride_ff;
   logic                 csr_write;
   logic                 csr_known;

   // blit progress
   logic [ROWS_W-1:0]    row_ff, row_in;
   logic [COLS_W-1:0]    col_ff, col_in;
   logic [ROWBASE_W-1:0] row_base_ff, row_base_in;
   logic [ORIGIN_W-1:0]  origin_ff, origin_in;
   logic [PROD_W-1:0]    y_times_stride;

   // clearing sweep
   logic                 clr_busy_ff;
   logic [AW-1:0]        clr_addr_ff;

   // issue stage: holds the accepted word while its memory operations go out
   logic                 s1_valid_ff;
   action_type           s1_act_ff;
   logic [DATA_W-1:0]    s1_data_ff;
   logic [FADDR_W-1:0]   s1_faddr_ff;
   logic                 s1_phase_ff;

   logic [2:0]           shift;
   logic                 split;
   logic                 last_phase;
   logic                 room;
   logic                 issue;
   logic                 issue_last;
   logic                 accept;
   logic [SUM_W-1:0]     blit_base, blit_next, host_addr, uop_sum;
   logic                 base_ok, next_ok, host_ok;
   logic [DATA_W-1:0]    hi_part, lo_part;
   logic [COLS_W-1:0]    cols_eff, col_inc;
   logic [ROWS_W-1:0]    rows_eff, row_inc;
   logic                 row_wrap, blit_finish;

   uop_kind_type         uop_kind;
   logic                 uop_ok;
   logic [DATA_W-1:0]    uop_value;
   logic                 uop_done;
   logic                 uop_oor;

   // memory stage
   logic                 m_valid_ff;
   uop_kind_type         m_kind_ff;
   logic [AW-1:0]        m_addr_ff;
   logic                 m_ok_ff;
   logic [DATA_W-1:0]    m_value_ff;
   logic                 m_last_ff;
   logic                 m_done_ff;
   logic                 m_oor_ff;

   logic [DATA_W-1:0]    frame_mem [FRAME_BYTES];
   logic [DATA_W-1:0]    rdata_ff;
   logic                 wr_valid_ff;
   logic [AW-1:0]        wr_addr_ff;
   logic [DATA_W-1:0]    wr_data_ff;

   logic [DATA_W-1:0]    old_byte;
   logic [DATA_W-1:0]    merged;
   logic                 wr_en;
   logic [DATA_W-1:0]    wr_data;

   rsp_word_type         rsp_push_word;
   rsp_word_type         rsp_word;
   logic                 rsp_push;
   logic [RSP_CNT_W-1:0] rsp_level;

   // ---------------------------------------------------------------- registers

   assign csr_ready = 1'b1;
   assign csr_known = (csr_index == CSR_X_POS) || (csr_index == CSR_Y_POS)
                   || (csr_index == CSR_ROW_COUNT) || (csr_index == CSR_BYTES_PER_ROW)
                   || (csr_index == CSR_RASTER_OP) || (csr_index == CSR_LINE_STRIDE);
   assign csr_write = csr_valid && csr_ready && csr_known;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_pos_ff         <= '0;
         y_pos_ff         <= '0;
         row_count_ff     <= ROWS_W'(1);
         bytes_per_row_ff <= COLS_W'(1);
         raster_op_ff     <= ROP_OR;
         line_stride_ff   <= STRIDE_W'(30);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_X_POS:         x_pos_ff         <= csr_data[XPOS_W-1:0];
            CSR_Y_POS:         y_pos_ff         <= csr_data[YPOS_W-1:0];
            CSR_ROW_COUNT:     row_count_ff     <= csr_data[ROWS_W-1:0];
            CSR_BYTES_PER_ROW: bytes_per_row_ff <= csr_data[COLS_W-1:0];
            CSR_RASTER_OP:     raster_op_ff     <= rop_type'(csr_data[ROP_W-1:0]);
            CSR_LINE_STRIDE:   line_stride_ff   <= csr_data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // top-left byte of the sprite, kept registered off the address path
   assign y_times_stride = y_pos_ff * line_stride_ff;
   assign origin_in = ORIGIN_W'(y_times_stride) + ORIGIN_W'(x_pos_ff[XPOS_W-1:3]);

   always_ff @(posedge clock) begin
      origin_ff <= origin_in;
   end

   // ---------------------------------------------------------------- issue stage

   assign shift      = x_pos_ff[2:0];
   assign split      = (s1_act_ff == ACT_SPRITE) && (shift != 3'd0);
   assign last_phase = !split || s1_phase_ff;
   assign room       = (rsp_level + RSP_CNT_W'(m_valid_ff && m_last_ff))
                       < RSP_CNT_W'(RSP_DEPTH);
   assign issue      = s1_valid_ff && (!last_phase || room);
   assign issue_last = issue && last_phase;
   assign req_tready = !clr_busy_ff && (!s1_valid_ff || issue_last);
   assign accept     = req_tvalid && req_tready;

   assign blit_base = SUM_W'(origin_ff) + SUM_W'(row_base_ff) + SUM_W'(col_ff);
   assign blit_next = blit_base + SUM_W'(1);
   assign host_addr = SUM_W'(s1_faddr_ff);
   assign base_ok   = blit_base < FRAME_LIMIT;
   assign next_ok   = blit_next < FRAME_LIMIT;
   assign host_ok   = host_addr < FRAME_LIMIT;

   assign hi_part = s1_data_ff >> shift;
   assign lo_part = s1_data_ff << (4'd8 - 4'(shift));

   assign cols_eff    = (bytes_per_row_ff == '0) ? COLS_W'(1) : bytes_per_row_ff;
   assign rows_eff    = (row_count_ff == '0) ? ROWS_W'(1) : row_count_ff;
   assign col_inc     = col_ff + COLS_W'(1);
   assign row_inc     = row_ff + ROWS_W'(1);
   assign row_wrap    = col_inc >= cols_eff;
   assign blit_finish = row_wrap && (row_inc >= rows_eff);

   always_comb begin
      uop_kind  = UOP_IDLE;
      uop_sum   = blit_base;
      uop_ok    = 1'b0;
      uop_value = '0;
      uop_done  = 1'b0;
      uop_oor   = 1'b0;
      unique case (s1_act_ff)
         ACT_SPRITE: begin
            uop_kind  = (raster_op_ff == ROP_KEEP) ? UOP_IDLE : UOP_COMBINE;
            uop_sum   = s1_phase_ff ? blit_next : blit_base;
            uop_ok    = s1_phase_ff ? next_ok : base_ok;
            uop_value = !split ? s1_data_ff : (s1_phase_ff ? lo_part : hi_part);
            uop_done  = blit_finish;
            uop_oor   = !base_ok || (split && !next_ok);
         end
         ACT_READ: begin
            uop_kind = UOP_LOAD;
            uop_sum  = host_addr;
            uop_ok   = host_ok;
            uop_oor  = !host_ok;
         end
         ACT_WRITE: begin
            uop_kind  = UOP_STORE;
            uop_sum   = host_addr;
            uop_ok    = host_ok;
            uop_value = s1_data_ff;
            uop_oor   = !host_ok;
         end
         ACT_NONE: begin
            uop_kind = UOP_IDLE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_phase_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         s1_phase_ff <= 1'b0;
      end else if (issue_last) begin
         s1_valid_ff <= 1'b0;
         s1_phase_ff <= 1'b0;
      end else if (issue) begin
         s1_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff   <= action_type'(req_tuser);
         s1_data_ff  <= req_tdata[DATA_W-1:0];
         s1_faddr_ff <= req_tdata[DATA_W+FADDR_W-1:DATA_W];
      end
   end

   // counters move once the last memory operation of a sprite byte is out
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      row_base_in = row_base_ff;
      if (csr_write) begin
         row_in      = '0;
         col_in      = '0;
         row_base_in = '0;
      end else if (issue_last && (s1_act_ff == ACT_SPRITE)) begin
         priority if (blit_finish) begin
            row_in      = '0;
            col_in      = '0;
            row_base_in = '0;
         end else if (row_wrap) begin
            row_in      = row_inc;
            col_in      = '0;
            row_base_in = row_base_ff + ROWBASE_W'(line_stride_ff);
         end else begin
            col_in = col_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         row_base_ff <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         row_base_ff <= row_base_in;
      end
   end

   // ---------------------------------------------------------------- memory stage

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      m_kind_ff  <= uop_kind;
      m_addr_ff  <= uop_sum[AW-1:0];
      m_ok_ff    <= uop_ok;
      m_value_ff <= uop_value;
      m_last_ff  <= last_phase;
      m_done_ff  <= uop_done;
      m_oor_ff   <= uop_oor;
   end

   // the byte written on the previous edge is not yet in the read data
   assign old_byte = (wr_valid_ff && (wr_addr_ff == m_addr_ff)) ? wr_data_ff : rdata_ff;

   always_comb begin
      unique case (raster_op_ff)
         ROP_OR:   merged = old_byte | m_value_ff;
         ROP_AND:  merged = old_byte & m_value_ff;
         ROP_XOR:  merged = old_byte ^ m_value_ff;
         ROP_KEEP: merged = old_byte;
         default:  merged = old_byte;
      endcase
   end

   assign wr_en   = m_valid_ff && m_ok_ff
                 && ((m_kind_ff == UOP_COMBINE) || (m_kind_ff == UOP_STORE));
   assign wr_data = (m_kind_ff == UOP_STORE) ? m_value_ff : merged;

   always_ff @(posedge clock) begin
      rdata_ff <= frame_mem[uop_sum[AW-1:0]];
      if (clr_busy_ff) begin
         frame_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         frame_mem[m_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= m_addr_ff;
      wr_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == CLEAR_LAST) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- results

   assign rsp_push = m_valid_ff && m_last_ff;

   always_comb begin
      rsp_push_word.read_data    = ((m_kind_ff == UOP_LOAD) && m_ok_ff) ? old_byte : '0;
      rsp_push_word.blit_done    = m_done_ff;
      rsp_push_word.out_of_range = m_oor_ff;
   end

   ssrb_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (rsp_push),
      .push_word  (rsp_push_word),
      .pop_ready  (rsp_tready),
      .pop_valid  (rsp_tvalid),
      .pop_word   (rsp_word),
      .level      (rsp_level)
   );

   assign rsp_tdata = rsp_word.read_data;
   assign rsp_tlast = rsp_word.blit_done;
   assign rsp_tuser = rsp_word.out_of_range;

   // ---------------------------------------------------------------- checks

   a_no_word_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_tready)
      else $error("word accepted during framebuffer clear");

   a_rsp_queue_has_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_level != RSP_CNT_W'(RSP_DEPTH)) || (rsp_tvalid && rsp_tready))
      else $error("result pushed into a full queue");

   a_second_half_only_when_split: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_phase_ff) |-> split)
      else $error("second destination byte issued for an aligned word");

   a_issue_reaches_memory_stage: assert property (@(posedge clock) disable iff (reset)
      issue_last |=> (m_valid_ff && m_last_ff))
      else $error("last memory operation of a word lost");

endmodule

`default_nettype wire

### tb/shifted_sprite_raster_blit_checker.sv
`timescale 1ns / 1ps

module shifted_sprite_raster_blit_checker
   import ssrb_pkg::*;
#(
   parameter int FRAME_BYTES = 4096
)
(
   input  wire                     clock,
   input  wire                     reset,

   input  wire                     req_tvalid,
   input  wire                     req_tready,
   input  wire [REQ_TDATA_W-1:0]   req_tdata,   // data_byte [7:0], fb_address [19:8], zero [23:20]
   input  wire [ACT_W-1:0]         req_tuser,   // action [1:0]

   input  wire                     rsp_tvalid,
   input  wire                     rsp_tready,
   input  wire [DATA_W-1:0]        rsp_tdata,   // read_data [7:0]
   input  wire                     rsp_tlast,
   input  wire [0:0]               rsp_tuser,   // out_of_range [0]

   input  wire                     csr_valid,
   input  wire                     csr_ready,
   input  wire [CSR_IDX_W-1:0]     csr_index,
   input  wire [CSR_DATA_W-1:0]    csr_data,

   output int                      failures,
   output int                      outstanding
);

   // shadow framebuffer and blit state
   logic [DATA_W-1:0]    fb_image [FRAME_BYTES];
   logic [XPOS_W-1:0]    x_pos;
   logic [YPOS_W-1:0]    y_pos;
   logic [ROWS_W-1:0]    row_count;
   logic [COLS_W-1:0]    bytes_per_row;
   rop_type              raster_op;
   logic [STRIDE_W-1:0]  line_stride;
   logic [ROWS_W-1:0]    row_at;
   logic [COLS_W-1:0]    col_at;
   logic [ROWBASE_W-1:0] row_base;

   rsp_word_type         pending_words [$];
   int                   words_seen;

   task automatic report_fault(string msg);
      $display("%0t: %s", $time, msg);
      failures++;
   endtask

   function automatic void restart_blit();
      row_at   = '0;
      col_at   = '0;
      row_base = '0;
   endfunction

   // returns 1 when the address lies outside the framebuffer
   function automatic logic merge_byte(int unsigned addr, logic [DATA_W-1:0] v);
      if (addr >= FRAME_BYTES) return 1'b1;
      case (raster_op)
         ROP_OR:  fb_image[addr] = fb_image[addr] | v;
         ROP_AND: fb_image[addr] = fb_image[addr] & v;
         ROP_XOR: fb_image[addr] = fb_image[addr] ^ v;
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      logic hit;
      hit = 1'b1;
      case (idx)
         CSR_X_POS:         x_pos         = v[XPOS_W-1:0];
         CSR_Y_POS:         y_pos         = v[YPOS_W-1:0];
         CSR_ROW_COUNT:     row_count     = v[ROWS_W-1:0];
         CSR_BYTES_PER_ROW: bytes_per_row = v[COLS_W-1:0];
         CSR_RASTER_OP:     raster_op     = rop_type'(v[ROP_W-1:0]);
         CSR_LINE_STRIDE:   line_stride   = v[STRIDE_W-1:0];
         default:           hit = 1'b0;
      endcase
      if (hit) restart_blit();
   endfunction

   function automatic rsp_word_type next_result_word(action_type act, logic [DATA_W-1:0] data,
                                                     logic [FADDR_W-1:0] faddr);
      rsp_word_type     w;
      logic [2:0]       shift;
      logic [ROWS_W-1:0] rows;
      logic [COLS_W-1:0] cols;
      int unsigned      dest;
      logic             miss;
      w = '0;
      case (act)
         ACT_SPRITE: begin
            shift = x_pos[2:0];
            rows  = (row_count == 0) ? ROWS_W'(1) : row_count;
            cols  = (bytes_per_row == 0) ? COLS_W'(1) : bytes_per_row;
            dest  = 32'(y_pos) * 32'(line_stride) + 32'(row_base) + 32'(x_pos >> 3)
                    + 32'(col_at);
            if (shift != 0) begin
               miss = merge_byte(dest, data >> shift);
               // the spill into the next byte is still done when the first misses
               miss = merge_byte(dest + 1, 8'(data << (4'd8 - shift))) | miss;
            end else begin
               miss = merge_byte(dest, data);
            end
            w.out_of_range = miss;
            col_at = col_at + 1'b1;
            if (col_at >= cols) begin
               col_at   = '0;
               row_at   = row_at + 1'b1;
               row_base = row_base + ROWBASE_W'(line_stride);
               if (row_at >= rows) begin
                  w.blit_done = 1'b1;
                  restart_blit();
               end
            end
         end
         ACT_READ: begin
            if (faddr < FRAME_BYTES) w.read_data = fb_image[faddr];
            else w.out_of_range = 1'b1;
         end
         ACT_WRITE: begin
            if (faddr < FRAME_BYTES) fb_image[faddr] = data;
            else w.out_of_range = 1'b1;
         end
         default: ;
      endcase
      return w;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         foreach (fb_image[i]) fb_image[i] = '0;
         x_pos         = '0;
         y_pos         = '0;
         row_count     = ROWS_W'(1);
         bytes_per_row = COLS_W'(1);
         raster_op     = ROP_OR;
         line_stride   = STRIDE_W'(30);
         restart_blit();
         pending_words.delete();
         words_seen = 0;
      end else begin
         // retire before predicting: a word out can never belong to the word going in
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               report_fault($sformatf("result word %0d arrived with nothing expected",
                                      words_seen));
            end else begin
               want = pending_words.pop_front();
               if (rsp_tdata !== want.read_data)
                  report_fault($sformatf("word %0d read_data %02h, expected %02h",
                                         words_seen, rsp_tdata, want.read_data));
               if (rsp_tlast !== want.blit_done)
                  report_fault($sformatf("word %0d blit_done %b, expected %b",
                                         words_seen, rsp_tlast, want.blit_done));
               if (rsp_tuser[0] !== want.out_of_range)
                  report_fault($sformatf("word %0d out_of_range %b, expected %b",
                                         words_seen, rsp_tuser[0], want.out_of_range));
            end
            words_seen++;
         end
         if (req_tvalid && req_tready)
            pending_words.push_back(next_result_word(action_type'(req_tuser),
                                                     req_tdata[DATA_W-1:0],
                                                     req_tdata[DATA_W +: FADDR_W]));
         if (csr_valid && csr_ready) apply_csr(csr_index, csr_data);
      end
      outstanding <= pending_words.size();
   end

endmodule

### tb/shifted_sprite_raster_blit_top_tb.sv
`timescale 1ns / 1ps

module shifted_sprite_raster_blit_top_tb;
   import ssrb_pkg::*;

   localparam int FRAME_BYTES = 4096;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [ACT_W-1:0]        req_tuser = '0;

   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_W-1:0]       rsp_tdata;
   logic                    rsp_tlast;
   logic [0:0]              rsp_tuser;

   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   int                      failures;
   int                      outstanding;
   int                      idle_pct = 0;
   int                      stall_pct = 0;
   int                      items_sent = 0;

   shifted_sprite_raster_blit_top #(.FRAME_BYTES(FRAME_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   shifted_sprite_raster_blit_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #(3_000_000);
      $display("FAIL");
      $finish;
   end

   task automatic send_word(action_type act, logic [DATA_W-1:0] data,
                            logic [FADDR_W-1:0] addr);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, addr, data};
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      if (act != ACT_NONE) items_sent++;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_regs(logic [8:0] x, y, rows, cols, rop, stride);
      wait_quiet();
      write_csr(CSR_X_POS, x);
      write_csr(CSR_Y_POS, y);
      write_csr(CSR_ROW_COUNT, rows);
      write_csr(CSR_BYTES_PER_ROW, cols);
      write_csr(CSR_RASTER_OP, rop);
      if ($urandom_range(3) == 0)
         write_csr($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, 9'($urandom));
      write_csr(CSR_LINE_STRIDE, stride);
      csr_valid <= 1'b0;
   endtask

   // an address inside or just past the sprite's footprint
   function automatic logic [FADDR_W-1:0] near_dest(int base, int stride, int rows, int cols);
      return FADDR_W'(base + $urandom_range((rows > 4 ? 4 : rows) - 1) * stride
                      + $urandom_range(cols > 8 ? 8 : cols));
   endfunction

   task automatic run_blit();
      logic [8:0] x_w, y_w, rows_w, cols_w, rop_w, stride_w;
      int         stride, rows_eff, cols_eff, base, n_sprite;
      stride = $urandom_range(1, 64);
      if ($urandom_range(9) == 0) stride = $urandom_range(127);
      x_w = 9'($urandom);
      y_w = 9'($urandom);
      // keep most blits inside the framebuffer
      if (stride != 0 && $urandom_range(9) != 0)
         y_w[7:0] = 8'($urandom_range((3800 / stride > 255) ? 255 : 3800 / stride));
      case ($urandom_range(39))
         0:       rows_w = 9'd0;
         1:       rows_w = 9'd256;
         2:       rows_w = 9'($urandom_range(257, 511));
         default: rows_w = 9'($urandom_range(1, 4));
      endcase
      case ($urandom_range(19))
         0:       cols_w = 9'd0;
         1:       cols_w = 9'd64;
         2:       cols_w = 9'($urandom_range(65, 127));
         default: cols_w = 9'($urandom_range(1, 6));
      endcase
      if (rows_w > 4 && $urandom_range(4) != 0) cols_w = 9'd1;
      cols_w[8:7] = 2'($urandom);
      rop_w    = 9'($urandom);
      stride_w = {2'($urandom), 7'(stride)};
      set_regs(x_w, y_w, rows_w, cols_w, rop_w, stride_w);

      rows_eff = (rows_w == 0) ? 1 : rows_w;
      cols_eff = (cols_w[6:0] == 0) ? 1 : cols_w[6:0];
      base     = y_w[7:0] * stride + x_w[8:3];
      n_sprite = rows_eff * cols_eff;
      if ($urandom_range(3) == 0) n_sprite += $urandom_range(1, cols_eff);
      else if ($urandom_range(7) == 0) n_sprite = $urandom_range(1, n_sprite);
      if (rows_eff * cols_eff <= 130 || (rows_eff == 256 && cols_eff == 1)) begin
         if (n_sprite > 260) n_sprite = 260;
      end else if (n_sprite > 48) begin
         n_sprite = 48;
      end

      if ($urandom_range(1))
         repeat ($urandom_range(1, 4))
            send_word(ACT_WRITE, 8'($urandom), near_dest(base, stride, rows_eff, cols_eff));
      for (int i = 0; i < n_sprite; i++) begin
         case ($urandom_range(19))
            0: send_word(ACT_READ, 8'($urandom), near_dest(base, stride, rows_eff, cols_eff));
            1: send_word(ACT_WRITE, 8'($urandom), near_dest(base, stride, rows_eff, cols_eff));
            2: send_word(ACT_NONE, 8'($urandom), 12'($urandom));
            3: send_word(action_type'(2'($urandom_range(1, 2))), 8'($urandom), 12'($urandom));
            default: ;
         endcase
         send_word(ACT_SPRITE, 8'($urandom), 12'($urandom));
      end
      repeat ($urandom_range(2, 8))
         send_word(ACT_READ, 8'($urandom), near_dest(base, stride, rows_eff, cols_eff));
   endtask

   initial begin
      int send_idle [4];
      int recv_stall [4];
      int blit_no;
      send_idle  = '{0, 56, 0, 19};
      recv_stall = '{0, 0, 56, 19};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // hold off until the framebuffer clear has finished
      do @(posedge clock); while (!req_tready);

      // host access at both ends of memory, ignored action, aligned sprite on reset values
      send_word(ACT_READ, 8'h00, 12'h000);
      send_word(ACT_WRITE, 8'hFF, 12'hFFF);
      send_word(ACT_READ, 8'h00, 12'hFFF);
      send_word(ACT_NONE, 8'hFF, 12'hFFF);
      send_word(ACT_SPRITE, 8'h81, 12'h000);
      send_word(ACT_READ, 8'h00, 12'h000);

      // two by two AND blit, shifted by three
      set_regs(9'd3, 9'd2, 9'd2, 9'd2, {7'd0, ROP_AND}, 9'd1);
      send_word(ACT_WRITE, 8'hFF, 12'h003);
      send_word(ACT_SPRITE, 8'hF0, 12'h000);
      send_word(ACT_SPRITE, 8'h0F, 12'h000);
      send_word(ACT_SPRITE, 8'hFF, 12'h000);
      send_word(ACT_SPRITE, 8'h00, 12'h000);
      send_word(ACT_READ, 8'h00, 12'h003);

      // last byte of memory with the spill falling off the end, zero sizes
      set_regs(9'd511, 9'd63, 9'd0, 9'd0, {7'd0, ROP_XOR}, 9'd64);
      send_word(ACT_SPRITE, 8'hFF, 12'h000);
      send_word(ACT_READ, 8'h00, 12'hFFF);
      set_regs(9'd511, 9'd63, 9'd1, 9'd1, {7'd0, ROP_KEEP}, 9'd64);
      send_word(ACT_SPRITE, 8'hFF, 12'h000);
      send_word(ACT_READ, 8'h00, 12'hFFF);

      // far corner, aligned, largest y position, line stride and bytes per row
      set_regs(9'd0, 9'd255, 9'd256, 9'd127, {7'd0, ROP_OR}, 9'd127);
      send_word(ACT_SPRITE, 8'hA5, 12'h000);

      blit_no = 0;
      while (items_sent < 1450) begin
         idle_pct  = send_idle[(blit_no / 3) % 4];
         stall_pct = recv_stall[(blit_no / 3) % 4];
         run_blit();
         blit_no++;
      end

      wait_quiet();
      repeat (12) @(posedge clock);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

### files.f
hdl/ssrb_pkg.sv
hdl/ssrb_rsp_fifo.sv
hdl/shifted_sprite_raster_blit_top.sv
tb/shifted_sprite_raster_blit_checker.sv
tb/shifted_sprite_raster_blit_top_tb.sv
